// File: rtl/scbsa_pkg.sv
`default_nettype none
package scbsa_pkg;

  localparam int NUM_SIZE_CLASSES_D = 32;
  localparam int SLOTS_PER_CLASS_D  = 4096;
  localparam int HEADER_BYTES_D     = 8;

  localparam int MAX_REQUEST = 8192;
  localparam int WORD_BITS   = 64;
  localparam int CLASS_W     = 5;
  localparam int SLOT_W      = 12;
  localparam int SIZE_W      = 16;
  localparam int OFS_W       = 26;
  localparam int CB_W        = 14;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_TOO_LARGE = 2'd2
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [SIZE_W-1:0]   request_size;
    logic [CLASS_W-1:0]  free_class;
    logic [SLOT_W-1:0]   free_slot;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [CLASS_W-1:0]  class_index;
    logic [SLOT_W-1:0]   slot_index;
    logic [OFS_W-1:0]    data_offset;
  } rsp_t;

  // Request to the offset unit: class and full-width slot number.
  typedef struct packed {
    logic [CLASS_W-1:0]  cls;
    logic [OFS_W-1:0]    slot;
  } ofs_req_t;

  localparam logic [CB_W-1:0] CLASS_BYTES [0:31] = '{
    14'd16,   14'd32,   14'd48,   14'd64,   14'd80,   14'd96,   14'd112,  14'd128,
    14'd160,  14'd192,  14'd224,  14'd256,
    14'd320,  14'd384,  14'd448,  14'd512,
    14'd640,  14'd768,  14'd896,  14'd1024,
    14'd1280, 14'd1536, 14'd1792, 14'd2048,
    14'd2560, 14'd3072, 14'd3584, 14'd4096,
    14'd5120, 14'd6144, 14'd7168, 14'd8192
  };

  // Round up to whole granules, then count the classes that are too small.
  function automatic logic [CLASS_W-1:0] class_of_size(input logic [SIZE_W-1:0] size);
    logic [SIZE_W:0]    need;
    logic [CLASS_W-1:0] cls;
    need = (17'(size) + 17'd15) & ~17'd15;
    cls  = '0;
    for (int i = 0; i < 31; i++) begin
      if (17'(CLASS_BYTES[i]) < need) begin
        cls = cls + 5'd1;
      end
    end
    return cls;
  endfunction

  function automatic logic [5:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [5:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = 6'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// File: rtl/scbsa_ram.sv
`default_nettype none
module scbsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/scbsa_offset.sv
`default_nettype none
module scbsa_offset #(
  parameter int HEADER_BYTES = scbsa_pkg::HEADER_BYTES_D
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire scbsa_pkg::ofs_req_t         req,
  output logic                             done,
  output logic [scbsa_pkg::OFS_W-1:0]      offset
);
  import scbsa_pkg::*;

  localparam logic [OFS_W-1:0] HDR = OFS_W'(HEADER_BYTES);

  logic [OFS_W-1:0] stride;
  logic [OFS_W-1:0] prod;
  logic             prod_vld;

  // Slot stride is class size plus header; only the low 26 bits matter.
  assign stride = OFS_W'(CLASS_BYTES[req.cls]) + HDR;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      prod_vld <= start;
      done     <= prod_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= OFS_W'(req.slot * stride);
    end
    if (prod_vld) begin
      offset <= prod + HDR;
    end
  end

endmodule
`default_nettype wire

// File: rtl/size_class_bitmap_slot_allocator.sv
// Size-class slot allocator over a per-class free bitmap held in one RAM.
//
// Request channel (req_valid / req_stall / req_data): action 0 allocates a
// slot for request_size bytes, action 1 frees (free_class, free_slot).
// Response channel (rsp_valid / rsp_stall / rsp_data): one response per
// request, in order, carrying status, class, slot and user-data offset.
//
// Requests are handled one at a time. An allocate takes lookup, one bitmap
// word read per cycle of the chosen class (up to WPC = SLOTS_PER_CLASS/64
// words, rounded up), a writeback and a two-stage offset multiply; a size
// that is too large answers after lookup without a scan. A free reads the
// word, sets the bit and writes it back; a handle out of range skips the
// bit update and writeback. The single read port of the bitmap RAM sets
// the allocate scan time.
//
// After reset the block sweeps the whole bitmap to all ones, one word per
// cycle, with req_stall high; bits past SLOTS_PER_CLASS in the last word
// of each class stay zero. The response sits in an output register; while
// rsp_stall is high it holds, and the block takes one more request and
// parks its finished response until the register frees up.
`default_nettype none
module size_class_bitmap_slot_allocator #(
  parameter int NUM_SIZE_CLASSES = scbsa_pkg::NUM_SIZE_CLASSES_D,
  parameter int SLOTS_PER_CLASS  = scbsa_pkg::SLOTS_PER_CLASS_D,
  parameter int HEADER_BYTES     = scbsa_pkg::HEADER_BYTES_D
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire scbsa_pkg::req_t   req_data,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output scbsa_pkg::rsp_t        rsp_data
);
  import scbsa_pkg::*;

  // Bitmap geometry.
  localparam int WPC   = (SLOTS_PER_CLASS + 63) / 64;
  localparam int TOTAL = NUM_SIZE_CLASSES * WPC;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int WW    = (WPC > 1) ? $clog2(WPC) : 1;
  localparam int WCW   = $clog2(WPC + 1);
  localparam int LAST_BITS = SLOTS_PER_CLASS % 64;
  localparam logic [WORD_BITS-1:0] LAST_WORD = (LAST_BITS == 0) ? {WORD_BITS{1'b1}} :
                                               ((64'd1 << LAST_BITS) - 64'd1);
  localparam logic [AW-1:0]  WPC_AW     = AW'(WPC);
  localparam logic [AW-1:0]  LAST_ADDR  = AW'(TOTAL - 1);
  localparam logic [WW-1:0]  LAST_W     = WW'(WPC - 1);
  localparam logic [WCW-1:0] WPC_CNT    = WCW'(WPC);
  localparam logic [5:0]     CLS_LIMIT  = 6'(NUM_SIZE_CLASSES);
  localparam logic [16:0]    SLOT_LIMIT = 17'(SLOTS_PER_CLASS);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_LOOKUP = 9'b000000100,
    S_SCAN   = 9'b000001000,
    S_WBACK  = 9'b000010000,
    S_FREAD  = 9'b000100000,
    S_FMOD   = 9'b001000000,
    S_MUL    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state;

  // Request and working registers.
  req_t                 req_r;
  rsp_t                 res;
  logic [CLASS_W-1:0]   cls_r;
  logic [AW-1:0]        base_addr;
  logic [WCW-1:0]       iss_w;
  logic                 rd_pend;
  logic [WW-1:0]        rd_w;
  logic [WORD_BITS-1:0] hit_word;
  logic [AW-1:0]        hit_addr;
  logic [WW-1:0]        hit_w;
  logic [AW-1:0]        fr_addr;
  logic [AW-1:0]        clr_addr;
  logic [WW-1:0]        clr_w;

  // Bitmap RAM ports.
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;

  // Offset unit.
  logic                 ofs_start;
  ofs_req_t             ofs_req;
  logic                 ofs_done;
  logic [OFS_W-1:0]     ofs_val;

  logic                 req_acc;
  logic                 rsp_take;
  logic [CLASS_W-1:0]   lk_cls;
  logic                 lk_large;
  logic                 fr_ok;
  logic [AW-1:0]        fr_word_addr;
  logic [AW-1:0]        scan_addr;
  logic                 iss_more;
  logic                 rd_hit;
  logic [5:0]           hit_bit;
  logic [OFS_W-1:0]     alloc_slot;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign rsp_take  = !rsp_valid || !rsp_stall;

  // Class lookup on the held request.
  assign lk_cls   = class_of_size(req_r.request_size);
  assign lk_large = (req_r.request_size > 16'(MAX_REQUEST)) || ({1'b0, lk_cls} >= CLS_LIMIT);

  // Free handle check and word address.
  assign fr_ok = ({1'b0, req_r.free_class} < CLS_LIMIT) &&
                 (17'(req_r.free_slot) < SLOT_LIMIT);
  assign fr_word_addr = AW'(req_r.free_class) * WPC_AW + AW'(req_r.free_slot[11:6]);

  // Scan issues one word read per cycle; the read data comes back registered.
  assign iss_more  = (iss_w < WPC_CNT);
  assign scan_addr = base_addr + AW'(iss_w[WW-1:0]);
  assign rd_addr   = (state == S_FREAD) ? fr_word_addr : scan_addr;
  assign rd_hit    = rd_pend && (rd_data != '0);

  assign hit_bit    = lowest_set(hit_word);
  assign alloc_slot = OFS_W'({hit_w, hit_bit});

  // Write port: clearing sweep, allocate writeback, free read-modify-write.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = {WORD_BITS{1'b1}};
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = (clr_w == LAST_W) ? LAST_WORD : {WORD_BITS{1'b1}};
      end
      S_WBACK: begin
        wr_en   = 1'b1;
        wr_addr = hit_addr;
        wr_data = hit_word & (hit_word - 64'd1);
      end
      S_FMOD: begin
        wr_en   = 1'b1;
        wr_addr = fr_addr;
        wr_data = rd_data | (64'd1 << req_r.free_slot[5:0]);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Offset unit start: after an allocate hit, after a free (good or bad handle).
  always_comb begin
    ofs_start    = 1'b0;
    ofs_req.cls  = req_r.free_class;
    ofs_req.slot = OFS_W'(req_r.free_slot);
    case (state)
      S_WBACK: begin
        ofs_start    = 1'b1;
        ofs_req.cls  = cls_r;
        ofs_req.slot = alloc_slot;
      end
      S_FMOD: begin
        ofs_start = 1'b1;
      end
      S_FREAD: begin
        ofs_start = !fr_ok;
      end
      default: begin
        ofs_start = 1'b0;
      end
    endcase
  end

  scbsa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(TOTAL)
  ) u_bitmap (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  scbsa_offset #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_offset (
    .clk   (clk),
    .rst   (rst),
    .start (ofs_start),
    .req   (ofs_req),
    .done  (ofs_done),
    .offset(ofs_val)
  );

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_w     <= '0;
      iss_w     <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // Load a finished response, or drop the one the receiver took.
      if (state == S_DONE && rsp_take) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          clr_w    <= (clr_w == LAST_W) ? '0 : clr_w + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_acc) begin
            state <= (req_data.action == ACT_FREE) ? S_FREAD : S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          iss_w   <= '0;
          rd_pend <= 1'b0;
          state   <= lk_large ? S_DONE : S_SCAN;
        end
        S_SCAN: begin
          if (iss_more) begin
            iss_w   <= iss_w + 1'b1;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_hit) begin
            state <= S_WBACK;
          end else if (rd_pend && rd_w == LAST_W) begin
            state <= S_DONE;
          end
        end
        S_WBACK: begin
          state <= S_MUL;
        end
        S_FREAD: begin
          state <= fr_ok ? S_FMOD : S_MUL;
        end
        S_FMOD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (ofs_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req_acc) begin
      req_r <= req_data;
    end
    case (state)
      S_LOOKUP: begin
        cls_r           <= lk_cls;
        base_addr       <= AW'(lk_cls) * WPC_AW;
        res.status      <= lk_large ? ST_TOO_LARGE : ST_FULL;
        res.class_index <= lk_large ? '0 : lk_cls;
        res.slot_index  <= '0;
        res.data_offset <= '0;
      end
      S_SCAN: begin
        if (iss_more) begin
          rd_w <= iss_w[WW-1:0];
        end
        if (rd_hit) begin
          hit_word <= rd_data;
          hit_addr <= base_addr + AW'(rd_w);
          hit_w    <= rd_w;
        end
      end
      S_WBACK: begin
        res.status     <= ST_OK;
        res.slot_index <= alloc_slot[SLOT_W-1:0];
      end
      S_FREAD: begin
        fr_addr         <= fr_word_addr;
        res.status      <= ST_OK;
        res.class_index <= req_r.free_class;
        res.slot_index  <= req_r.free_slot;
        res.data_offset <= '0;
      end
      S_MUL: begin
        if (ofs_done) begin
          res.data_offset <= ofs_val;
        end
      end
      S_DONE: begin
        if (rsp_take) begin
          rsp_data <= res;
        end
      end
      default: begin
      end
    endcase
  end

  // Only the sweep, the allocate writeback and the free update touch the bitmap.
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CLEAR || state == S_WBACK || state == S_FMOD))
    else $error("bitmap write outside a write state");

  // A writeback always consumes a word that had a free slot.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WBACK) |-> (hit_word != '0))
    else $error("allocate writeback of an empty word");

  // The offset unit answers only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    ofs_done |-> (state == S_MUL))
    else $error("offset result outside the multiply wait");

  // A rejected size carries no class, slot or offset.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status == ST_TOO_LARGE) |->
      (rsp_data.class_index == '0 && rsp_data.slot_index == '0 &&
       rsp_data.data_offset == '0))
    else $error("size-too-large response with nonzero fields");

  // The clearing sweep hands over to idle and nothing else.
  assert property (@(posedge clk) disable iff (rst)
    ($past(state == S_CLEAR) && state != S_CLEAR) |-> (state == S_IDLE))
    else $error("clearing sweep left to a busy state");

endmodule
`default_nettype wire
